### hw/rtl/epr_pkg.sv
// Shared types and constants for the emulation prevention remover.
// No dependencies.
package epr_pkg;

  localparam logic [7:0] EprThree = 8'h03;
  localparam logic [1:0] EprRunMax = 2'd2;

  // Decision for one input byte: optional re-emitted 0x03, then optional byte.
  typedef struct packed {
    logic       rel_three;
    logic       emit_byte;
    logic [7:0] data;
    logic       last;
  } epr_res_t;

endpackage

### hw/rtl/epr_unescape.sv
// Escape decision logic and zero-run / held-byte state.
// Depends on epr_pkg.
module epr_unescape (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [7:0]        data_i,
  input  logic              last_i,
  output epr_pkg::epr_res_t res_o
);
  import epr_pkg::*;

  logic [1:0] zero_run_q, zero_run_d;
  logic       held_q, held_d;
  logic       cand;

  always_comb begin
    cand           = (data_i == EprThree) && (zero_run_q == EprRunMax) && !last_i;
    res_o.rel_three = held_q && (data_i > EprThree);
    res_o.emit_byte = !cand;
    res_o.data      = data_i;
    res_o.last      = last_i;

    held_d = cand;
    if (last_i) begin
      zero_run_d = '0;
    end else if (data_i == 8'h00) begin
      zero_run_d = (zero_run_q == EprRunMax) ? zero_run_q : zero_run_q + 2'd1;
    end else begin
      zero_run_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q <= '0;
      held_q     <= 1'b0;
    end else if (adv_i) begin
      zero_run_q <= zero_run_d;
      held_q     <= held_d;
    end
  end

endmodule

### hw/rtl/epr_result.sv
// Result buffer: two output beats, so a released 0x03 and its byte fit at once.
// Depends on epr_pkg.
module epr_result (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  epr_pkg::epr_res_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o
);
  import epr_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  beat_t      head_q, head_d, tail_q, tail_d;
  logic       head_vld_q, head_vld_d, tail_vld_q, tail_vld_d;
  beat_t      first_beat, byte_beat;
  logic [1:0] n_load;
  logic [1:0] n_keep;
  logic [2:0] n_after;
  logic       take;

  assign out_valid_o = head_vld_q;
  assign take        = head_vld_q && !out_stall_i;
  assign out_byte_o  = head_q.data;
  assign out_last_o  = head_q.last;

  assign n_load  = {1'b0, res_i.rel_three} + {1'b0, res_i.emit_byte};
  // beats still here once this cycle's head leaves
  assign n_keep  = {1'b0, head_vld_q} + {1'b0, tail_vld_q} - {1'b0, take};
  assign n_after = {1'b0, n_keep} + {1'b0, n_load};
  assign free_o  = (n_after <= 3'd2);

  assign byte_beat  = {res_i.data, res_i.last};
  assign first_beat = res_i.rel_three ? {EprThree, 1'b0} : byte_beat;

  always_comb begin
    head_d     = head_q;
    head_vld_d = head_vld_q;
    tail_d     = tail_q;
    tail_vld_d = tail_vld_q;
    if (take) begin
      head_d     = tail_q;
      head_vld_d = tail_vld_q;
      tail_vld_d = 1'b0;
    end
    if (load_i && (n_load != 2'd0)) begin
      if (!head_vld_d) begin
        head_d     = first_beat;
        head_vld_d = 1'b1;
      end else begin
        tail_d     = first_beat;
        tail_vld_d = 1'b1;
      end
      // released 0x03 sits at the head; load_i only comes with room for both
      if (res_i.rel_three) begin
        tail_d     = byte_beat;
        tail_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      tail_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      tail_vld_q <= tail_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

### hw/rtl/emulation_prevention_remover.sv
// Emulation prevention remover: EBSP byte stream in, RBSP byte stream out.
// Top level; depends on epr_pkg, epr_unescape and epr_result.
//
// Usage:
//   Input channel: one encapsulated byte per beat (data_byte_i, last_in_i
//   marking the packet's final byte), in_valid_i / in_stall_o.
//   Output channel: one raw byte per beat (out_byte_o, out_last_o),
//   out_valid_o / out_stall_i.
//   A 0x03 after two zeros is held until the next byte; it is dropped when
//   that byte is 0x00..0x03, otherwise sent just before it. A candidate that
//   ends the packet is passed as is. Zero run and held byte clear at packet end.
// Path: an accepted beat passes the input register, then the result register,
//   on its way to the output.
// Throughput: one input beat per cycle while out_stall_i is low. A beat that
//   releases a held 0x03 yields two output beats and the held beat before it
//   yields none; the two-beat result buffer absorbs the difference, so the
//   sustained rate stays one per cycle.
// Stall: while out_stall_i is high the result buffer holds its beats and
//   in_stall_o rises once the input beat's result no longer fits in it.
// Reset: rst_ni clears all pending beats, the zero run and the held byte.
module emulation_prevention_remover (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);
  import epr_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_data_q;
  logic       in_last_q;
  logic       res_free;
  logic       adv;
  epr_res_t   res;

  assign adv        = in_vld_q && res_free;
  assign in_stall_o = in_vld_q && !res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= data_byte_i;
      in_last_q <= last_in_i;
    end
  end

  epr_unescape u_unescape (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .data_i (in_data_q),
    .last_i (in_last_q),
    .res_o  (res)
  );

  epr_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .res_i       (res),
    .free_o      (res_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

### hw/rtl/epr_checker.sv
// Port-level checks for the emulation prevention remover, bound to the top.
// Depends on emulation_prevention_remover.
module epr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] data_byte_i,
  input logic       last_in_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(out_last_o))
    else $error("stalled output beat changed");

  // input only backs up behind a pending result
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  // stalled input beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(data_byte_i)
      && $stable(last_in_i))
    else $error("stalled input beat changed");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid after reset");

endmodule

bind emulation_prevention_remover epr_checker u_epr_checker (.*);
